// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pts assertion failed");

`endif

// ===== src/pts_pkg.sv =====
// Package: sizes, codes, types and helpers for the priority task selector.
package pts_pkg;

	localparam int MAX_TASKS = 8;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int IDX_W     = 3;
	localparam int PRI_W     = 8;
	localparam int TICK_W    = 32;
	localparam int RUN_W     = 3;
	localparam int MEM_W     = TICK_W + PRI_W;

	typedef logic [1:0] op_t;
	localparam op_t OP_ADD   = 2'd0;
	localparam op_t OP_SLEEP = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLP_RD,
		ST_SLP_WR,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] task_index;
		logic             found;
		logic             pend_switch;
		logic             table_full;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [MEM_W-1:0]  wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

	// Slot number as reported on task_index (masked or zero-extended).
	function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] slot);
		return IDX_W'(slot);
	endfunction

endpackage

// ===== src/priority_task_selector_unit.sv =====
// Top level of the fixed-priority task selector: task memory, sequencer, result register.
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+------------------------------------------------
//  in      | in        | in_valid / in_ready | op, priority_req, sleep_ticks, running_task
//  out     | out       | out_valid/out_ready | task_index, found, pend_switch, table_full
//
// An add writes the new entry and finishes; a select scans the N used slots (N = tasks added
// so far, at most MAX_TASKS); a sleep of a used slot first does a read-modify-write of the
// sleeping slot's entry, then scans. The scan reads one slot per cycle from the task memory port.
// Reset clears the slot count, the ready bits and the sequencer; the memory is not cleared.
// One beat is in flight at a time; a finished result parks in the output register, so
// the next input beat is taken while that result waits for out_ready.
module priority_task_selector_unit
	import pts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [PRI_W-1:0]  priority_req,
	input  logic [TICK_W-1:0] sleep_ticks,
	input  logic [RUN_W-1:0]  running_task,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  task_index,
	output logic              found,
	output logic              pend_switch,
	output logic              table_full
);

	mem_req_t         mem_req;
	logic [MEM_W-1:0] mem_rdata;
	logic             push, out_free;
	res_t             res;
	res_t             out_q;
	logic             out_valid_q;

	// each entry: {sleep tick count, priority}
	pts_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_TASKS)
	) u_task_mem (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	pts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.priority_req(priority_req),
		.sleep_ticks (sleep_ticks),
		.running_task(running_task),
		.out_free    (out_free),
		.push        (push),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	// output register frees up in the same cycle its beat is taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign task_index  = out_q.task_index;
	assign found       = out_q.found;
	assign pend_switch = out_q.pend_switch;
	assign table_full  = out_q.table_full;

endmodule

// ===== src/pts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/pts_ctrl.sv =====
// Sequencer: add, sleep read-modify-write, and the slot scan over the task memory.
module pts_ctrl
	import pts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  op_t               op,
	input  logic [PRI_W-1:0]  priority_req,
	input  logic [TICK_W-1:0] sleep_ticks,
	input  logic [RUN_W-1:0]  running_task,
	input  logic              out_free,
	output logic              push,
	output res_t              res,
	output mem_req_t          mem_req,
	input  logic [MEM_W-1:0]  mem_rdata
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAX_TASKS-1:0] ready_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [RUN_W-1:0]  run_q;
	logic [TICK_W-1:0] ticks_q;
	logic              is_add_q;
	res_t              add_res_q;
	logic [CNT_W-1:0]  scan_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              have_q;
	logic [SLOT_W-1:0] best_q;
	logic [PRI_W-1:0]  best_pri_q;

	logic accept, full, run_used, scan_more, take;
	logic [SLOT_W-1:0] run_slot;
	res_t sel_res;
	res_t add_res_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (cnt_q == CNT_W'(MAX_TASKS));
	assign run_used  = (32'(running_task) < 32'(cnt_q));
	assign run_slot  = SLOT_W'(run_q);
	assign scan_more = (scan_q < cnt_q);
	// lowest number wins; <= lets the later (higher) slot win a tie
	assign take      = vld_s1 && ready_q[idx_s1] &&
		(!have_q || (mem_rdata[PRI_W-1:0] <= best_pri_q));

	always_comb begin
		sel_res = '0;
		if (have_q) begin
			sel_res.task_index  = to_idx(best_q);
			sel_res.found       = 1'b1;
			sel_res.pend_switch = (32'(best_q) != 32'(run_q));
		end else begin
			sel_res.task_index  = to_idx(next_slot_q);
		end
	end

	// add result: slot on success, only table_full when refused
	always_comb begin
		add_res_d            = '0;
		add_res_d.table_full = full;
		add_res_d.found      = !full;
		if (!full) begin
			add_res_d.task_index = to_idx(cnt_q[SLOT_W-1:0]);
		end
	end

	assign res  = is_add_q ? add_res_q : sel_res;
	assign push = (state_q == ST_FIN) && out_free;

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_ADD) && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cnt_q[SLOT_W-1:0];
					mem_req.wdata = {{TICK_W{1'b0}}, priority_req};
				end
			end
			ST_SLP_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = run_slot;
			end
			ST_SLP_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = run_slot;
				mem_req.wdata = {ticks_q, mem_rdata[PRI_W-1:0]};
			end
			ST_SCAN: begin
				mem_req.re    = scan_more;
				mem_req.raddr = scan_q[SLOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_ADD) begin
						state_d = ST_FIN;
					end else if (op == OP_SLEEP && run_used) begin
						state_d = ST_SLP_RD;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SLP_RD: state_d = ST_SLP_WR;
			ST_SLP_WR: state_d = ST_SCAN;
			ST_SCAN: begin
				if (!scan_more) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ready_q     <= '0;
			next_slot_q <= '0;
			vld_s1      <= 1'b0;
			have_q      <= 1'b0;
		end else begin
			if (accept) begin
				have_q <= 1'b0;
				if (op == OP_ADD && !full) begin
					cnt_q                       <= cnt_q + 1'b1;
					ready_q[cnt_q[SLOT_W-1:0]] <= 1'b1;
				end
			end
			if (state_q == ST_SLP_WR) begin
				ready_q[run_slot] <= 1'b0;
			end
			vld_s1 <= (state_q == ST_SCAN) && scan_more;
			if (take) begin
				have_q <= 1'b1;
			end
			if (push && !is_add_q && have_q) begin
				next_slot_q <= best_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			run_q     <= running_task;
			ticks_q   <= sleep_ticks;
			is_add_q  <= (op == OP_ADD);
			scan_q    <= '0;
			add_res_q <= add_res_d;
		end
		if (state_q == ST_SCAN && scan_more) begin
			scan_q <= scan_q + 1'b1;
			idx_s1 <= scan_q[SLOT_W-1:0];
		end
		if (take) begin
			best_q     <= idx_s1;
			best_pri_q <= mem_rdata[PRI_W-1:0];
		end
	end

endmodule

// ===== src/pts_checker.sv =====
// Port-level checker for the priority task selector, bound to the top level.
`include "assert_macros.svh"

module pts_checker
	import pts_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [IDX_W-1:0] task_index,
	input logic             found,
	input logic             pend_switch,
	input logic             table_full
);

	// a stalled result beat stays put
	`PTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(task_index) && $stable(found) && $stable(pend_switch) && $stable(table_full))

	// one beat in flight: the input side closes right after taking a beat
	`PTS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a refused add reports nothing else
	`PTS_ASSERT_IMP(a_full_clean, clk, arst_n, out_valid && table_full, !found && !pend_switch && (task_index == '0))

	// a switch is only requested for a task that was found
	`PTS_ASSERT_IMP(a_switch_found, clk, arst_n, out_valid && pend_switch, found)

endmodule

bind priority_task_selector_unit pts_checker u_pts_checker (.*);
